/* rtl/cpd_pkg.sv */
// cpd_pkg: shared constants, types and the byte-wide crc-32 update for the
// crc-32 packet deframer. no dependencies.
`timescale 1ns / 1ps

package cpd_pkg;

  localparam int unsigned HdrBytes  = 8;
  localparam int unsigned CrcBytes  = 4;
  localparam int unsigned MinFrame  = HdrBytes + CrcBytes;
  localparam int unsigned CountW    = 10;
  localparam int unsigned FillW     = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned TypeW     = 3;

  localparam logic [CountW-1:0] CountMax          = '1;
  localparam logic [15:0]       MaxPayloadDefault = 16'd512;
  localparam logic [31:0]       CrcPoly           = 32'hEDB88320;

  localparam logic [TypeW-1:0] DataTypeReset = 3'd1;
  localparam logic [TypeW-1:0] AckTypeReset  = 3'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDataType = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAckType  = 2'd1;

  // result item kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef enum logic [2:0] {
    StatusOk     = 3'd0,
    StatusNoHdr  = 3'd1,
    StatusLenErr = 3'd2,
    StatusBadType = 3'd3,
    StatusCrcErr = 3'd4
  } status_e;

  typedef struct packed {
    logic        emit;
    logic        item_kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [2:0]  packet_type;
    logic [4:0]  window_size;
    logic [7:0]  sequence_number;
    logic [15:0] declared_length;
    logic [31:0] time_stamp;
    logic [31:0] received_crc;
  } result_t;

  // zero-seeded running crc-32, one byte, reflected form
  function automatic logic [31:0] crc32_add_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return ~c;
  endfunction

endpackage

/* rtl/cpd_in_if.sv */
// cpd_in_if: byte input channel of the deframer.
// depends on cpd_pkg for nothing; plain valid/ready with payload.
`timescale 1ns / 1ps

interface cpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, frame_byte, end_of_frame, input ready);
  modport sink   (input valid, frame_byte, end_of_frame, output ready);
endinterface

/* rtl/cpd_out_if.sv */
// cpd_out_if: result channel of the deframer (payload bytes and summaries).
// plain valid/ready with payload, no dependencies.
`timescale 1ns / 1ps

interface cpd_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [2:0]  packet_type;
  logic [4:0]  window_size;
  logic [7:0]  sequence_number;
  logic [15:0] declared_length;
  logic [31:0] time_stamp;
  logic [31:0] received_crc;

  modport source (output valid, item_kind, payload_byte, status, packet_type,
                  window_size, sequence_number, declared_length, time_stamp,
                  received_crc, input ready);
  modport sink   (input valid, item_kind, payload_byte, status, packet_type,
                  window_size, sequence_number, declared_length, time_stamp,
                  received_crc, output ready);
endinterface

/* rtl/cpd_cfg_if.sv */
// cpd_cfg_if: configuration write channel of the deframer.
// depends on cpd_pkg for the index and data widths.
`timescale 1ns / 1ps

interface cpd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cpd_pkg::CfgIdxW-1:0]   index;
  logic [cpd_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/cpd_frame_state.sv */
// cpd_frame_state: per-frame state (count, crc, tail, header holds) and the
// result of one byte step. depends on cpd_pkg.
`timescale 1ns / 1ps

module cpd_frame_state #(
  parameter logic [15:0] MaxPayload = cpd_pkg::MaxPayloadDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                byte_i,
  input  logic                      eof_i,
  input  logic [cpd_pkg::TypeW-1:0] data_type_i,
  input  logic [cpd_pkg::TypeW-1:0] ack_type_i,
  output cpd_pkg::result_t          result_o
);
  import cpd_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [31:0]       crc_q, crc_d;
  logic [31:0]       tail_q, tail_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [7:0]        hdr0_q, hdr0_d;
  logic [7:0]        seq_q, seq_d;
  logic [15:0]       len_q, len_d;
  logic [31:0]       stamp_q, stamp_d;

  logic              push;
  logic              fwd;
  logic [CountW-1:0] pay_len;
  logic [2:0]        ptype;
  status_e           status;

  always_comb begin
    hdr0_d  = hdr0_q;
    seq_d   = seq_q;
    len_d   = len_q;
    stamp_d = stamp_q;
    case (count_q)
      10'd0: hdr0_d = byte_i;
      10'd1: seq_d = byte_i;
      10'd2: len_d[15:8] = byte_i;
      10'd3: len_d[7:0] = byte_i;
      10'd4: stamp_d[31:24] = byte_i;
      10'd5: stamp_d[23:16] = byte_i;
      10'd6: stamp_d[15:8] = byte_i;
      10'd7: stamp_d[7:0] = byte_i;
      default: ;
    endcase
  end

  // the byte leaving the four-byte tail enters the crc
  assign push    = (fill_q == FillW'(CrcBytes));
  assign crc_d   = push ? crc32_add_byte(crc_q, tail_q[31:24]) : crc_q;
  assign fill_d  = push ? fill_q : fill_q + 1'b1;
  assign tail_d  = {tail_q[23:0], byte_i};
  assign count_d = (count_q != CountMax) ? count_q + 1'b1 : count_q;

  assign fwd = (count_q >= CountW'(HdrBytes)) &&
               ({6'd0, count_q - CountW'(HdrBytes)} < len_q);

  assign pay_len = count_d - CountW'(MinFrame);
  assign ptype   = hdr0_d[7:5];

  always_comb begin
    if (count_d < CountW'(MinFrame)) begin
      status = StatusNoHdr;
    end else if ({6'd0, pay_len} > MaxPayload) begin
      status = StatusLenErr;
    end else if (ptype != data_type_i && ptype != ack_type_i) begin
      status = StatusBadType;
    end else if (len_d != {6'd0, pay_len}) begin
      status = StatusLenErr;
    end else if (crc_d != tail_d) begin
      status = StatusCrcErr;
    end else begin
      status = StatusOk;
    end
  end

  always_comb begin
    result_o = '0;
    result_o.status = StatusOk;
    if (eof_i) begin
      result_o.emit            = 1'b1;
      result_o.item_kind       = KindSummary;
      result_o.status          = status;
      result_o.packet_type     = ptype;
      result_o.window_size     = hdr0_d[4:0];
      result_o.sequence_number = seq_d;
      result_o.declared_length = len_d;
      result_o.time_stamp      = stamp_d;
      result_o.received_crc    = tail_d;
    end else if (fwd) begin
      result_o.emit         = 1'b1;
      result_o.item_kind    = KindPayload;
      result_o.payload_byte = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
      hdr0_q  <= '0;
      seq_q   <= '0;
      len_q   <= '0;
      stamp_q <= '0;
    end else if (step_i) begin
      if (eof_i) begin
        count_q <= '0;
        crc_q   <= '0;
        tail_q  <= '0;
        fill_q  <= '0;
        hdr0_q  <= '0;
        seq_q   <= '0;
        len_q   <= '0;
        stamp_q <= '0;
      end else begin
        count_q <= count_d;
        crc_q   <= crc_d;
        tail_q  <= tail_d;
        fill_q  <= fill_d;
        hdr0_q  <= hdr0_d;
        seq_q   <= seq_d;
        len_q   <= len_d;
        stamp_q <= stamp_d;
      end
    end
  end

endmodule

/* rtl/crc32_packet_deframer_top.sv */
// Byte-stream deframer with crc-32 check: one frame byte is taken per clock
// while the output is not stalled, and every request moves through an input
// register, one step of frame logic and an output register. Payload bytes
// come out as they arrive; the last byte of a frame gives a summary with the
// header fields and a status. The rate is set by the byte-wide crc-32 xor
// tree between the input and output registers. Type codes are to be written
// through the configuration channel while no frame is in flight; the user is
// bound by this, and the block itself does not enforce it.
// depends on cpd_pkg, cpd_in_if, cpd_out_if, cpd_cfg_if, cpd_frame_state.
`timescale 1ns / 1ps

module crc32_packet_deframer_top #(
  parameter logic [15:0] MaxPayload = cpd_pkg::MaxPayloadDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpd_in_if.sink    in_chan,
  cpd_out_if.source out_chan,
  cpd_cfg_if.sink   cfg_chan
);
  import cpd_pkg::*;

  logic [TypeW-1:0] data_type_q, ack_type_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_eof_q;

  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  result_t    res;
  logic       advance;
  logic       step;

  // configuration
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_type_q <= DataTypeReset;
      ack_type_q  <= AckTypeReset;
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == CfgDataType) begin
        data_type_q <= cfg_chan.data[TypeW-1:0];
      end else if (cfg_chan.index == CfgAckType) begin
        ack_type_q <= cfg_chan.data[TypeW-1:0];
      end
    end
  end

  // input stage moves on whenever the output slot is free or being drained
  assign advance       = !out_valid_q || out_chan.ready;
  assign step          = s1_valid_q && advance;
  assign in_chan.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_q <= in_chan.frame_byte;
      s1_eof_q  <= in_chan.end_of_frame;
    end
  end

  cpd_frame_state #(
    .MaxPayload(MaxPayload)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (s1_byte_q),
    .eof_i      (s1_eof_q),
    .data_type_i(data_type_q),
    .ack_type_i (ack_type_q),
    .result_o   (res)
  );

  // output register
  assign out_valid_d = step ? res.emit : (out_valid_q && !out_chan.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.emit) begin
      out_q <= res;
    end
  end

  assign out_chan.valid           = out_valid_q;
  assign out_chan.item_kind       = out_q.item_kind;
  assign out_chan.payload_byte    = out_q.payload_byte;
  assign out_chan.status          = out_q.status;
  assign out_chan.packet_type     = out_q.packet_type;
  assign out_chan.window_size     = out_q.window_size;
  assign out_chan.sequence_number = out_q.sequence_number;
  assign out_chan.declared_length = out_q.declared_length;
  assign out_chan.time_stamp      = out_q.time_stamp;
  assign out_chan.received_crc    = out_q.received_crc;

endmodule

/* verif/crc32_packet_deframer_top_tb.sv */
// crc32_packet_deframer_top_tb: self-checking bench for the crc-32 packet deframer.
// it builds frames, predicts every forwarded byte and summary, and checks them.
// depends on cpd_pkg, cpd_in_if, cpd_out_if, cpd_cfg_if and crc32_packet_deframer_top.
`timescale 1ns / 1ps

module crc32_packet_deframer_top_tb;
  import cpd_pkg::*;

  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned SettleCycles   = 6;
  localparam int unsigned RandomByteGoal = 210;
  localparam int unsigned PrintCap       = 30;
  localparam int unsigned HoldOffCycles  = 400;

  // indexes past the two type registers, writes there must do nothing
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    status_e     status;
    logic [2:0]  ptype;
    logic [4:0]  window;
    logic [7:0]  seq;
    logic [15:0] dlen;
    logic [31:0] stamp;
    logic [31:0] rcrc;
  } frame_result_t;

  logic clk;
  logic rst_n;

  cpd_in_if  in_chan ();
  cpd_out_if out_chan ();
  cpd_cfg_if cfg_chan ();

  crc32_packet_deframer_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // deframer tracking state
  logic [CountW-1:0] trk_count;
  logic [31:0]       trk_crc;
  logic [31:0]       trk_tail;
  logic [FillW-1:0]  trk_fill;
  logic [7:0]        trk_hdr0;
  logic [7:0]        trk_seq;
  logic [15:0]       trk_len;
  logic [31:0]       trk_stamp;
  logic [TypeW-1:0]  data_code = DataTypeReset;
  logic [TypeW-1:0]  ack_code  = AckTypeReset;

  frame_result_t pending_results[$];
  logic [7:0]    frame_buf[$];

  int unsigned sent_bytes     = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned burst_left     = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_len       = 0;
  int unsigned hold_tag       = 0;

  function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = ~acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ CrcPoly;
      else r = r >> 1;
    end
    return ~r;
  endfunction

  function void clear_tracker();
    trk_count = '0;
    trk_crc   = '0;
    trk_tail  = '0;
    trk_fill  = '0;
    trk_hdr0  = '0;
    trk_seq   = '0;
    trk_len   = '0;
    trk_stamp = '0;
  endfunction

  function void predict_byte(input logic [7:0] b, input logic last);
    logic [CountW-1:0] pos;
    int unsigned total;
    frame_result_t res;
    pos = trk_count;
    res = '0;
    case (pos)
      0: trk_hdr0 = b;
      1: trk_seq = b;
      2: trk_len[15:8] = b;
      3: trk_len[7:0] = b;
      4: trk_stamp[31:24] = b;
      5: trk_stamp[23:16] = b;
      6: trk_stamp[15:8] = b;
      7: trk_stamp[7:0] = b;
      default: ;
    endcase
    // the byte leaving the four-byte tail is the one that enters the crc
    if (trk_fill >= CrcBytes) trk_crc = crc_fold(trk_crc, trk_tail[31:24]);
    else trk_fill++;
    trk_tail = {trk_tail[23:0], b};
    if (trk_count != CountMax) trk_count++;
    if (!last) begin
      if (pos >= HdrBytes && (pos - HdrBytes) < trk_len) begin
        res.kind    = KindPayload;
        res.payload = b;
        pending_results.push_back(res);
      end
    end else begin
      total    = trk_count;
      res.kind = KindSummary;
      if (total < MinFrame) res.status = StatusNoHdr;
      else if (total - MinFrame > MaxPayloadDefault) res.status = StatusLenErr;
      else if (trk_hdr0[7:5] != data_code && trk_hdr0[7:5] != ack_code)
        res.status = StatusBadType;
      else if (trk_len != total - MinFrame) res.status = StatusLenErr;
      else if (trk_crc != trk_tail) res.status = StatusCrcErr;
      else res.status = StatusOk;
      res.ptype  = trk_hdr0[7:5];
      res.window = trk_hdr0[4:0];
      res.seq    = trk_seq;
      res.dlen   = trk_len;
      res.stamp  = trk_stamp;
      res.rcrc   = trk_tail;
      pending_results.push_back(res);
      clear_tracker();
    end
  endfunction

  function void build_frame(input logic [2:0] ptype, input logic [4:0] win,
                            input logic [7:0] seq, input logic [15:0] dlen,
                            input logic [31:0] stamp, input int unsigned payload_len);
    logic [31:0] crc;
    frame_buf = {};
    frame_buf.push_back({ptype, win});
    frame_buf.push_back(seq);
    frame_buf.push_back(dlen[15:8]);
    frame_buf.push_back(dlen[7:0]);
    frame_buf.push_back(stamp[31:24]);
    frame_buf.push_back(stamp[23:16]);
    frame_buf.push_back(stamp[15:8]);
    frame_buf.push_back(stamp[7:0]);
    repeat (payload_len) frame_buf.push_back(8'($urandom_range(0, 255)));
    crc = '0;
    foreach (frame_buf[i]) crc = crc_fold(crc, frame_buf[i]);
    frame_buf.push_back(crc[31:24]);
    frame_buf.push_back(crc[23:16]);
    frame_buf.push_back(crc[15:8]);
    frame_buf.push_back(crc[7:0]);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PrintCap) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, name,
                                got, want));
  endtask

  // sender: bursts of requests with random gaps, sometimes back to back
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_chan.valid        <= 1'b1;
    in_chan.frame_byte   <= b;
    in_chan.end_of_frame <= last;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    predict_byte(b, last);
    sent_bytes++;
  endtask

  task automatic send_frame_buf();
    for (int i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic send_good_frame(input logic [2:0] ptype, input int unsigned plen);
    build_frame(ptype, 5'($urandom), 8'($urandom), 16'(plen), $urandom, plen);
    send_frame_buf();
  endtask

  task automatic idle_until_drained();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a trailing crc byte gives no result but may still be in flight
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    if (idx == CfgDataType) data_code = val[TypeW-1:0];
    else if (idx == CfgAckType) ack_code = val[TypeW-1:0];
  endtask

  task automatic set_type_codes(input logic [TypeW-1:0] d, input logic [TypeW-1:0] a);
    idle_until_drained();
    write_reg(CfgDataType, {5'($urandom), d});
    write_reg(CfgAckType, {5'($urandom), a});
    write_reg($urandom_range(0, 1) ? CfgUnusedLo : CfgUnusedHi, 8'($urandom));
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic test_header_fields();
    build_frame(data_code, 5'h00, 8'h00, 16'd0, 32'h0000_0000, 0);
    send_frame_buf();
    build_frame(ack_code, 5'h1F, 8'hFF, 16'd3, 32'hFFFF_FFFF, 3);
    send_frame_buf();
    send_good_frame(data_code, 7);
  endtask

  task automatic test_status_codes();
    // crc mismatch, in the crc field and in the payload
    build_frame(data_code, 5'($urandom), 8'($urandom), 16'd5, $urandom, 5);
    frame_buf[frame_buf.size() - 1] ^= 8'h01;
    send_frame_buf();
    build_frame(ack_code, 5'($urandom), 8'($urandom), 16'd6, $urandom, 6);
    frame_buf[9] ^= 8'h80;
    send_frame_buf();
    // declared length too long forwards crc bytes too, then too short
    build_frame(data_code, 5'($urandom), 8'($urandom), 16'd7, $urandom, 4);
    send_frame_buf();
    build_frame(data_code, 5'($urandom), 8'($urandom), 16'd3, $urandom, 4);
    send_frame_buf();
    // unknown types, also ahead of a length error and of a bad crc
    send_good_frame(3'd0, 2);
    send_good_frame(3'd7, 1);
    build_frame(3'd7, 5'($urandom), 8'($urandom), 16'd9, $urandom, 2);
    send_frame_buf();
    build_frame(3'd0, 5'($urandom), 8'($urandom), 16'd2, $urandom, 2);
    frame_buf[frame_buf.size() - 2] ^= 8'h10;
    send_frame_buf();
  endtask

  task automatic test_short_frames();
    int unsigned trunc_lens[7] = '{1, 2, 3, 4, 5, 8, 11};
    foreach (trunc_lens[k]) begin
      build_frame(data_code, 5'($urandom), 8'($urandom), 16'hFFFF, $urandom, 0);
      while (frame_buf.size() > trunc_lens[k]) void'(frame_buf.pop_back());
      send_frame_buf();
    end
  endtask

  task automatic test_type_registers();
    logic [TypeW-1:0] data_set[4];
    logic [TypeW-1:0] ack_set[4];
    logic [TypeW-1:0] other;
    data_set = '{3'd0, 3'd7, 3'd4, 3'($urandom)};
    ack_set  = '{3'd7, 3'd0, 3'd4, 3'($urandom)};
    foreach (data_set[k]) begin
      set_type_codes(data_set[k], ack_set[k]);
      send_good_frame(data_code, 2);
      send_good_frame(ack_code, 1);
      do other = 3'($urandom); while (other == data_code || other == ack_code);
      send_good_frame(other, 0);
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off while frames keep coming, so the input must stall
    hold_len = HoldOffCycles;
    hold_tag++;
    repeat (6) send_good_frame(($urandom_range(0, 1) != 0) ? data_code : ack_code, 10);
    idle_until_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned start_bytes;
    int unsigned r;
    int unsigned plen;
    logic [2:0]  ptype;
    logic [15:0] dlen;
    start_bytes = sent_bytes;
    while (sent_bytes - start_bytes < RandomByteGoal) begin
      if ($urandom_range(0, 15) == 0) set_type_codes(3'($urandom), 3'($urandom));
      r     = $urandom_range(0, 99);
      plen  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
      ptype = ($urandom_range(0, 1) != 0) ? data_code : ack_code;
      dlen  = 16'(plen);
      if (r >= 73 && r < 80) dlen = ($urandom_range(0, 1) != 0) ? 16'(plen + 1) : 16'($urandom);
      if (r >= 80 && r < 87) ptype = 3'($urandom);
      build_frame(ptype, 5'($urandom), 8'($urandom), dlen, $urandom, plen);
      if (r >= 65 && r < 73) begin
        frame_buf[$urandom_range(0, frame_buf.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end else if (r >= 87 && r < 94) begin
        r = $urandom_range(1, MinFrame - 1);
        while (frame_buf.size() > r) void'(frame_buf.pop_back());
      end else if (r >= 94) begin
        frame_buf = {};
        repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom));
      end
      send_frame_buf();
    end
  endtask

  // receiver: stall pattern changes per epoch, a hold-off request overrides it
  initial begin : receiver
    int unsigned hold_left;
    int unsigned seen_tag;
    int unsigned epoch_left;
    int unsigned mode;
    logic [15:0] pattern;
    hold_left  = 0;
    seen_tag   = 0;
    epoch_left = 0;
    mode       = 0;
    pattern    = '1;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (seen_tag != hold_tag) begin
        seen_tag  = hold_tag;
        hold_left = hold_len;
      end
      if (epoch_left == 0) begin
        epoch_left = $urandom_range(16, 96);
        mode       = $urandom_range(0, 3);
        pattern    = 16'($urandom);
      end
      epoch_left--;
      pattern = {pattern[14:0], pattern[15]};
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (mode)
          1: out_chan.ready <= pattern[0];
          2: out_chan.ready <= ($urandom_range(0, 3) == 0);
          default: out_chan.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending, kind %0d",
                                  results_seen, out_chan.item_kind));
      end else begin
        want = pending_results.pop_front();
        check_field("item_kind", out_chan.item_kind, want.kind);
        check_field("payload_byte", out_chan.payload_byte, want.payload);
        check_field("status", out_chan.status, want.status);
        check_field("packet_type", out_chan.packet_type, want.ptype);
        check_field("window_size", out_chan.window_size, want.window);
        check_field("sequence_number", out_chan.sequence_number, want.seq);
        check_field("declared_length", out_chan.declared_length, want.dlen);
        check_field("time_stamp", out_chan.time_stamp, want.stamp);
        check_field("received_crc", out_chan.received_crc, want.rcrc);
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.frame_byte   <= '0;
    in_chan.end_of_frame <= 1'b0;
    cfg_chan.valid       <= 1'b0;
    cfg_chan.index       <= CfgDataType;
    cfg_chan.data        <= '0;
    clear_tracker();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_fields();
    test_status_codes();
    test_short_frames();
    test_type_registers();
    test_backpressure();
    test_random_traffic();

    idle_until_drained();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
